// ----- rtl/core/sha256_pkg.sv -----
// Shared types, constants and the rotate helper of the SHA-256 digest block.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_byte;   // write byte into buffer at fill position
    logic pad_mark;    // write 0x80 at fill position, zero the rest
    logic zero_all;    // zero whole buffer
    logic put_len;     // write bit length into last 8 bytes
    logic start_blk;   // load schedule and working words
    logic do_round;    // run one round
    logic fold;        // add working words into chain
    logic clear_msg;   // restore initial hash, clear counts
  } dp_cmd_t;

  typedef struct packed {
    logic       fill_full;  // fill count reaches 64 after this byte
    logic       long_tail;  // fill >= 56 at end of message
    logic       last_round;
  } dp_stat_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadMark    = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/core/sha256_ctrl.sv -----
// Sequencer for byte loading, padding, compression rounds and digest output.
module sha256_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha256_pkg::in_word_t in_word_i,
  input  sha256_pkg::dp_stat_t stat_i,
  output sha256_pkg::dp_cmd_t  cmd_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRound, StFold, StPadLen, StEmit
  } state_e;

  state_e state_q;
  logic   final_q;     // block in flight is the length block
  logic   need_len_q;  // a spill block follows the block in flight
  logic   out_valid_q;
  logic   accept;

  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_byte = in_word_i.has_byte;
          if (in_word_i.has_byte && stat_i.fill_full) begin
            cmd_o.start_blk = 1'b1;
          end else if (in_word_i.end_of_message) begin
            cmd_o.pad_mark  = 1'b1;
            cmd_o.put_len   = !stat_i.long_tail;
            cmd_o.start_blk = 1'b1;
          end
        end
      end
      StRound:  cmd_o.do_round = 1'b1;
      StFold:   cmd_o.fold = 1'b1;
      StPadLen: begin
        cmd_o.zero_all  = 1'b1;
        cmd_o.put_len   = 1'b1;
        cmd_o.start_blk = 1'b1;
      end
      StEmit:   cmd_o.clear_msg = !out_stall_i;
      default:  cmd_o = '0;
    endcase
  end

  // A full block on an end item: load, compress, then pad in a fresh block.
  logic pend_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      final_q     <= 1'b0;
      need_len_q  <= 1'b0;
      pend_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (in_word_i.has_byte && stat_i.fill_full) begin
              state_q    <= StRound;
              final_q    <= 1'b0;
              need_len_q <= 1'b0;
              pend_end_q <= in_word_i.end_of_message;
            end else if (in_word_i.end_of_message) begin
              state_q    <= StRound;
              final_q    <= !stat_i.long_tail;
              need_len_q <= stat_i.long_tail;
              pend_end_q <= 1'b0;
            end
          end
        end
        StRound: if (stat_i.last_round) state_q <= StFold;
        StFold: begin
          if (final_q) begin
            state_q     <= StEmit;
            out_valid_q <= 1'b1;
          end else if (need_len_q) begin
            state_q <= StPadLen;
          end else if (pend_end_q) begin
            state_q <= StPadLen;
          end else begin
            state_q <= StIdle;
          end
        end
        StPadLen: begin
          // spill block holds only zeros and length; an end after a full
          // block needs the mark at byte 0 as well (handled by datapath)
          state_q    <= StRound;
          final_q    <= 1'b1;
          need_len_q <= 1'b0;
        end
        StEmit: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
            pend_end_q  <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- rtl/core/sha256_dp.sv -----
// Block buffer, bit counter, schedule window, round logic and chaining words.
module sha256_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha256_pkg::in_word_t  in_word_i,
  input  sha256_pkg::dp_cmd_t   cmd_i,
  input  logic                  mark_first_i,
  output sha256_pkg::dp_stat_t  stat_o,
  output sha256_pkg::out_word_t out_word_o
);
  import sha256_pkg::*;

  // The schedule window doubles as the block buffer: bytes land big-endian
  // in its sixteen words while the input is open.
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  rnd_q;
  logic [6:0]  fill_after;
  logic [5:0]  pad_pos;
  logic [63:0] len_bits;

  // Fill and length as they stand once this cycle's byte is in.
  assign fill_after = {1'b0, fill_q} + {6'd0, in_word_i.has_byte};
  assign pad_pos    = fill_q + {5'd0, cmd_i.load_byte};
  assign len_bits   = cmd_i.load_byte ? bits_q + 64'd8 : bits_q;

  assign stat_o.fill_full  = (fill_q == 6'd63);
  assign stat_o.long_tail  = (fill_after >= 7'd56);
  assign stat_o.last_round = (rnd_q == 6'd63);

  // Buffer next value: byte write, padding and length insertion.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      w_d[j] = w_q[j];
      for (int k = 0; k < 4; k++) begin
        if (cmd_i.load_byte && fill_q == 6'(4*j+k))
          w_d[j][8*(3-k) +: 8] = in_word_i.message_byte;
        if (cmd_i.pad_mark) begin
          if (pad_pos == 6'(4*j+k))     w_d[j][8*(3-k) +: 8] = PadMark;
          else if (pad_pos < 6'(4*j+k)) w_d[j][8*(3-k) +: 8] = 8'h00;
        end
        if (cmd_i.zero_all)
          w_d[j][8*(3-k) +: 8] = (mark_first_i && j == 0 && k == 0) ? PadMark : 8'h00;
      end
      if (cmd_i.put_len && j == 14) w_d[j] = len_bits[63:32];
      if (cmd_i.put_len && j == 15) w_d[j] = len_bits[31:0];
    end
  end

  // Round datapath, one round per cycle over a sliding schedule window.
  logic [31:0] wt, s0, s1, t1, t2, a, e, w15, w2;
  always_comb begin
    w15 = w_q[1];
    w2  = w_q[14];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wt  = w_q[0];
    a   = v_q[0];
    e   = v_q[4];
    t1  = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
          ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[rnd_q] + wt;
    t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
          ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_round) begin
      for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
      w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
    end else begin
      for (int j = 0; j < 16; j++) w_q[j] <= w_d[j];
    end
    if (cmd_i.start_blk) begin
      for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
    end else if (cmd_i.do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= e;
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= a;
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
    end else begin
      if (cmd_i.load_byte) begin
        fill_q <= fill_q + 6'd1;
        bits_q <= bits_q + 64'd8;
      end
      if (cmd_i.start_blk) rnd_q <= '0;
      else if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
      end
      if (cmd_i.clear_msg) begin
        fill_q <= '0;
        bits_q <= '0;
        for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
      end
    end
  end

  assign out_word_o.digest_word_0 = {h_q[0], h_q[1]};
  assign out_word_o.digest_word_1 = {h_q[2], h_q[3]};
  assign out_word_o.digest_word_2 = {h_q[4], h_q[5]};
  assign out_word_o.digest_word_3 = {h_q[6], h_q[7]};
endmodule

// ----- rtl/core/sha256_message_digest.sv -----
// Top level of the streaming SHA-256 digest block.
//
//   channel | direction | handshake            | word
//   in      | sink      | in_valid_i/in_stall_o | sha256_pkg::in_word_t
//   out     | source    | out_valid_o/out_stall_i | sha256_pkg::out_word_t
//
// A byte that does not complete a block is only buffered. A byte that fills
// the block starts a compression: a load, 64 rounds of the single round unit
// and a fold. An end item costs one or two such blocks (a second when 56 or
// more bytes are buffered, or when its own byte filled the block), then the
// digest waits in the output register until taken. Input stalls through all
// of that. Reset restores the initial hash and clears the counters; no
// clearing pass is needed.
module sha256_message_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_word_t out_word_o
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     mark_first;

  // A zero-fill block that follows a full data block carries the pad mark
  // at byte 0; the spill block after a long tail does not.
  logic mark_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (cmd.start_blk && !cmd.zero_all) begin
      mark_q <= !(cmd.pad_mark);
    end
  end
  assign mark_first = mark_q;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  sha256_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_word_i    (in_word_i),
    .cmd_i        (cmd),
    .mark_first_i (mark_first),
    .stat_o       (stat),
    .out_word_o   (out_word_o)
  );
endmodule

// ----- rtl/core/sha256_checker.sv -----
// Port-level checks of the digest block, bound to the top level.
module sha256_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);
  // No input taken while a digest waits.
  a_no_in_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while digest pending");

  // A digest holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("digest dropped");

  // A taken digest reopens the input on the next cycle.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o && !in_stall_o)
    else $error("input not reopened");

  // A stalled input word stays offered.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i) else $error("stalled word withdrawn");
endmodule

bind sha256_message_digest sha256_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
